// ===== rtl/rtt_pkg.sv =====
// Shared types and codes for the retransmit timer table.
// Holds the input and result payload structs, the queued command and the table slot layout.
// No dependencies.
`timescale 1ns / 1ps

package rtt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	// Command codes as carried on the input
	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// Result kinds
	localparam logic [2:0] RES_RESEND     = 3'd0;
	localparam logic [2:0] RES_SCAN_DONE  = 3'd1;
	localparam logic [2:0] RES_PUSH_OK    = 3'd2;
	localparam logic [2:0] RES_PUSH_FULL  = 3'd3;
	localparam logic [2:0] RES_CANCELLED  = 3'd4;
	localparam logic [2:0] RES_NOT_CANCEL = 3'd5;

	// Destination address kinds
	localparam logic [1:0] AK_LOCAL   = 2'd0;
	localparam logic [1:0] AK_REAL    = 2'd1;
	localparam logic [1:0] AK_VIRTUAL = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] entry_id;
		logic [15:0] packet_handle;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [2:0]  dest_flags;
		logic [31:0] timeout_secs;
		logic [7:0]  max_tries;
		logic [31:0] now_secs;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [15:0] out_id;
		logic [15:0] out_handle;
		logic [31:0] out_ip;
		logic [15:0] out_port;
		logic [1:0]  address_kind;
		logic [7:0]  try_number;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [15:0] ident;
		logic [15:0] handle;
		logic [31:0] ip;
		logic [15:0] port;
		logic        destroyed;
		logic [2:0]  flags;
		logic [31:0] timeout;
		logic [31:0] last_sent;
		logic [7:0]  limit;
		logic [7:0]  tries;
	} slot_t;

	// A command as it waits in the queue: push commands carry their new slot ready-made.
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] id;
		slot_t       entry;
		logic [31:0] now;
	} cmd_t;

endpackage

// ===== rtl/rtt_front.sv =====
// Front end of the retransmit timer table: takes input transfers and classifies them.
// Depends on rtt_pkg; feeds the command queue.
`timescale 1ns / 1ps

module rtt_front (
	input  logic              item_valid,
	output logic              item_ready,
	input  rtt_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_wr,
	output rtt_pkg::cmd_t     q_data
);
	import rtt_pkg::*;

	assign item_ready = !q_full;

	// CMD_NONE commands are taken and dropped here, so the back end never sees them.
	assign q_wr = item_valid && !q_full && (item.command != CMD_NONE);

	always_comb begin
		q_data                 = '0;
		q_data.op              = item.command;
		q_data.id              = item.entry_id;
		q_data.now             = item.now_secs;
		q_data.entry.ident     = item.entry_id;
		q_data.entry.handle    = item.packet_handle;
		q_data.entry.ip        = item.dest_ip;
		q_data.entry.port      = item.dest_port;
		q_data.entry.destroyed = 1'b0;
		q_data.entry.flags     = item.dest_flags;
		q_data.entry.timeout   = item.timeout_secs;
		q_data.entry.last_sent = 32'd0;
		q_data.entry.limit     = item.max_tries;
		q_data.entry.tries     = 8'd0;
	end

endmodule

// ===== rtl/rtt_cmd_fifo.sv =====
// Two-entry command queue between the front end and the table engine.
// Depends on rtt_pkg for the command type.
`timescale 1ns / 1ps

module rtt_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  rtt_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd,
	output logic          rd_valid,
	output rtt_pkg::cmd_t rd_data
);
	import rtt_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full     = (fill_q == 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({wr, rd})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/rtt_engine.sv =====
// Back end of the retransmit timer table: holds the slot memory and carries out
// push, cancel and scan commands, one slot per cycle while the result output is not
// held, into a registered result stage. Depends on rtt_pkg.
`timescale 1ns / 1ps

module rtt_engine #(
	parameter int TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  rtt_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               result_valid,
	input  logic               result_ready,
	output rtt_pkg::out_item_t result
);
	import rtt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CANCEL = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	slot_t mem [TABLE_DEPTH];
	slot_t rd_q;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] keep_q, keep_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             res_valid_q;
	out_item_t        res_q;

	logic             out_ok;
	logic             last_idx;
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	slot_t            mem_wdata;
	logic             emit;
	out_item_t        emit_data;

	logic        removed;
	logic        due;
	logic [31:0] elapsed;
	logic [7:0]  tries_next;
	slot_t       upd;
	logic [1:0]  akind;

	assign out_ok       = !res_valid_q || result_ready;
	assign last_idx     = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Evaluation of the slot whose registered read data is on hand
	always_comb begin
		removed    = rd_q.destroyed || ((rd_q.limit != 8'd0) && (rd_q.tries >= rd_q.limit));
		elapsed    = cmd.now - rd_q.last_sent;
		due        = (elapsed > rd_q.timeout);
		tries_next = (rd_q.tries != 8'hFF) ? (rd_q.tries + 8'd1) : rd_q.tries;
		upd        = rd_q;
		if (due) begin
			upd.tries     = tries_next;
			upd.last_sent = cmd.now;
		end
		priority if (rd_q.flags[0]) begin
			akind = AK_LOCAL;
		end else if (rd_q.flags[1]) begin
			akind = AK_REAL;
		end else begin
			akind = AK_VIRTUAL;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		keep_d    = keep_q;
		idx_d     = idx_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rd_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		emit_data = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_ok) begin
					emit_data.out_id = cmd.id;
					unique case (cmd.op)
						CMD_PUSH: begin
							cmd_pop               = 1'b1;
							emit                  = 1'b1;
							emit_data.last_result = 1'b1;
							if (count_q == DEPTH_C) begin
								emit_data.result_kind = RES_PUSH_FULL;
							end else begin
								mem_we                = 1'b1;
								mem_waddr             = count_q[IDX_W-1:0];
								mem_wdata             = cmd.entry;
								count_d               = count_q + CNT_W'(1);
								emit_data.result_kind = RES_PUSH_OK;
							end
						end
						CMD_CANCEL: begin
							if (count_q == '0) begin
								cmd_pop               = 1'b1;
								emit                  = 1'b1;
								emit_data.result_kind = RES_NOT_CANCEL;
								emit_data.last_result = 1'b1;
							end else begin
								mem_re  = 1'b1;
								idx_d   = '0;
								state_d = ST_CANCEL;
							end
						end
						CMD_TICK: begin
							if (count_q == '0) begin
								cmd_pop               = 1'b1;
								emit                  = 1'b1;
								emit_data             = '0;
								emit_data.result_kind = RES_SCAN_DONE;
								emit_data.last_result = 1'b1;
							end else begin
								mem_re  = 1'b1;
								idx_d   = '0;
								keep_d  = '0;
								state_d = ST_SCAN;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_CANCEL: begin
				if (out_ok) begin
					emit_data.out_id      = cmd.id;
					emit_data.last_result = 1'b1;
					priority if (rd_q.ident == cmd.id) begin
						cmd_pop = 1'b1;
						emit    = 1'b1;
						state_d = ST_IDLE;
						if (!rd_q.destroyed) begin
							mem_we                = 1'b1;
							mem_waddr             = idx_q;
							mem_wdata.destroyed   = 1'b1;
							emit_data.result_kind = RES_CANCELLED;
						end else begin
							emit_data.result_kind = RES_NOT_CANCEL;
						end
					end else if (last_idx) begin
						cmd_pop               = 1'b1;
						emit                  = 1'b1;
						emit_data.result_kind = RES_NOT_CANCEL;
						state_d               = ST_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_q + IDX_W'(1);
						idx_d     = idx_q + IDX_W'(1);
					end
				end
			end
			ST_SCAN: begin
				if (out_ok) begin
					// Surviving slots are packed down towards the front as the scan goes.
					if (!removed) begin
						mem_we    = 1'b1;
						mem_waddr = keep_q[IDX_W-1:0];
						mem_wdata = upd;
						keep_d    = keep_q + CNT_W'(1);
						if (due && (rd_q.flags != 3'd0)) begin
							emit                   = 1'b1;
							emit_data.result_kind  = RES_RESEND;
							emit_data.out_id       = rd_q.ident;
							emit_data.out_handle   = rd_q.handle;
							emit_data.out_ip       = rd_q.ip;
							emit_data.out_port     = rd_q.port;
							emit_data.address_kind = akind;
							emit_data.try_number   = tries_next;
						end
					end
					if (last_idx) begin
						state_d = ST_DONE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_q + IDX_W'(1);
						idx_d     = idx_q + IDX_W'(1);
					end
				end
			end
			ST_DONE: begin
				if (out_ok) begin
					cmd_pop               = 1'b1;
					emit                  = 1'b1;
					emit_data.result_kind = RES_SCAN_DONE;
					emit_data.last_result = 1'b1;
					count_d               = keep_q;
					state_d               = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			keep_q      <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			keep_q  <= keep_d;
			idx_q   <= idx_d;
			if (out_ok) begin
				res_valid_q <= emit;
			end
		end
	end

endmodule

// ===== rtl/retransmit_timer_table_unit.sv =====
// Retransmit timer table, top level. A push passes through the command queue and then the
// registered result stage; pushes run at one per cycle while the result output is not held.
// Cancel and tick commands step through the stored slots one at a time via the single read
// port of the slot memory. The two-entry command queue keeps taking input while the engine
// works, until it is full. Reset clears the fill count, the queue and the result stage; slot
// contents stay undefined and need no clearing pass, as only slots below the fill count are read.
`timescale 1ns / 1ps

module retransmit_timer_table_unit #(
	parameter int TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rtt_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output rtt_pkg::out_item_t result
);
	import rtt_pkg::*;

	logic q_full;
	logic q_wr;
	cmd_t q_wr_data;
	logic q_rd;
	logic q_valid;
	cmd_t q_rd_data;

	rtt_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_data     (q_wr_data)
	);

	rtt_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.rd       (q_rd),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	rtt_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (q_rd_data),
		.cmd_pop      (q_rd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
